// ===== rtl/core/atkd2_pkg.sv =====
// Shared types and constants for the 2-bit Atkinson ditherer.
`default_nettype none
package atkd2_pkg;

    typedef struct packed {
        logic [7:0] gray;
        logic [8:0] column;
        logic       first_of_image;
        logic       last_in_row;
    } pix_word_t;

    typedef struct packed {
        logic [1:0] level;
        logic [8:0] out_column;
    } dot_word_t;

    // tone adjusted pixel waiting for the dither engine
    typedef struct packed {
        logic [7:0] tone;
        logic [8:0] column;
        logic       first_of_image;
        logic       last_in_row;
    } tone_word_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    localparam logic [7:0] REG_ADJUST_ENABLE     = 8'd0;
    localparam logic [7:0] REG_CONTRAST_PERCENT  = 8'd1;
    localparam logic [7:0] REG_BRIGHTNESS_OFFSET = 8'd2;
    localparam logic [7:0] REG_GAMMA_ENABLE      = 8'd3;

    localparam logic [7:0] RST_CONTRAST   = 8'd115;
    localparam logic [5:0] RST_BRIGHTNESS = 6'd10;

    localparam logic [7:0] MID_GRAY = 8'd128;
    // ceil(2^22 / 100): exact floor(m / 100) for m < 2^15
    localparam logic [16:0] RECIP_100 = 17'd41944;
    localparam int          RECIP_SHIFT = 22;

    localparam logic [7:0] THR_DARK  = 8'd43;
    localparam logic [7:0] THR_LIGHT = 8'd128;
    localparam logic [7:0] THR_WHITE = 8'd213;
    localparam logic [7:0] VAL_DARK  = 8'd85;
    localparam logic [7:0] VAL_LIGHT = 8'd170;
    localparam logic [7:0] VAL_WHITE = 8'd255;

    localparam logic [1:0] LVL_BLACK = 2'd0;
    localparam logic [1:0] LVL_DARK  = 2'd1;
    localparam logic [1:0] LVL_LIGHT = 2'd2;
    localparam logic [1:0] LVL_WHITE = 2'd3;

    localparam int Q_DEPTH = 4;

endpackage
`default_nettype wire

// ===== rtl/core/atkinson_dither_2bit.sv =====
// Top level of the 2-bit Atkinson error-diffusion ditherer.
//
// Gray pixels enter in raster order as words on the pix channel and leave as
// 2-bit levels on the dot channel, one per pixel, in order. The front end
// takes no new word until the last is pushed; it passes words straight on
// with adjustment off, adds multiply, scale and adjust steps with adjustment
// on, and with gamma on also the bitwise divide of the square-root step, the
// longest of them. The dither engine does a read-modify-write of six error
// entries per pixel through the single write port of each row store and
// clears the freed row (all MAX_WIDTH+4 entries) after a last_in_row word and
// all rows on a first_of_image word. A 4-word queue between the two parts lets
// each run on its own; sustained rate is the slower of the two. After reset
// the row stores are cleared, during which pix_stall is high. Configuration
// writes are taken in any cycle and are meant for idle time.
`default_nettype none
module atkinson_dither_2bit #(
    parameter int MAX_WIDTH = 512
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [7:0]             cfg_index,
    input  wire logic [7:0]             cfg_data,
    input  wire logic                   pix_valid,
    output logic                        pix_stall,
    input  wire atkd2_pkg::pix_word_t   pix_word,
    output logic                        dot_valid,
    input  wire logic                   dot_stall,
    output atkd2_pkg::dot_word_t        dot_word
);
    import atkd2_pkg::*;

    cfg_wr_t    cfg;
    logic       boot_clear;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    tone_word_t q_in;
    tone_word_t q_out;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    atkd2_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .hold      (boot_clear),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_word    (q_in)
    );

    atkd2_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_word  (q_out),
        .empty     (q_empty)
    );

    atkd2_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_word     (q_out),
        .boot_clear (boot_clear),
        .dot_valid  (dot_valid),
        .dot_stall  (dot_stall),
        .dot_word   (dot_word)
    );

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_boot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        boot_clear |-> pix_stall)
        else $error("pixel taken during row store clear");

endmodule
`default_nettype wire

// ===== rtl/core/atkd2_row_mem.sv =====
// One error row store: one write port, one registered read port.
`default_nettype none
module atkd2_row_mem #(
    parameter int DEPTH = 516,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/atkd2_front.sv =====
// Front end: configuration registers, pixel intake and tone adjustment.
`default_nettype none
module atkd2_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire atkd2_pkg::cfg_wr_t     cfg,
    input  wire logic                   hold,
    input  wire logic                   pix_valid,
    output logic                        pix_stall,
    input  wire atkd2_pkg::pix_word_t   pix_word,
    input  wire logic                   q_full,
    output logic                        q_push,
    output atkd2_pkg::tone_word_t       q_word
);
    import atkd2_pkg::*;

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_MUL  = 7'b0000010,
        F_SCL  = 7'b0000100,
        F_ADJ  = 7'b0001000,
        F_DIV  = 7'b0010000,
        F_GAM  = 7'b0100000,
        F_PUSH = 7'b1000000
    } fstate_t;

    fstate_t    state_reg;
    logic       adj_en_reg;
    logic [7:0] pct_reg;
    logic [5:0] bri_reg;
    logic       gam_en_reg;
    tone_word_t word_reg;
    logic       neg_reg;
    logic [15:0] prod_reg;
    logic [8:0] quo_reg;
    logic [7:0] x1_reg;
    logic [7:0] rem_reg;
    logic [8:0] low_reg;
    logic [8:0] gq_reg;
    logic [3:0] cnt_reg;

    logic        accept;
    logic [7:0]  mag;
    logic [32:0] scl;
    logic signed [10:0] c_sgn;
    logic [7:0]  c1;
    logic [8:0]  c2_sum;
    logic [7:0]  c2;
    logic [15:0] g_prod;
    logic [8:0]  x1_sum;
    logic [8:0]  r2;
    logic        ge;
    logic [8:0]  r2_sub;
    logic [9:0]  x2_sum;
    logic [8:0]  x2;

    assign accept    = pix_valid && !pix_stall;
    assign pix_stall = (state_reg != F_IDLE) || hold;
    assign q_push    = (state_reg == F_PUSH) && !q_full;
    assign q_word    = word_reg;

    always_comb
    begin
        mag    = (word_reg.tone < MID_GRAY) ? (MID_GRAY - word_reg.tone)
                                            : (word_reg.tone - MID_GRAY);
        scl    = 33'(prod_reg) * 33'(RECIP_100);
        c_sgn  = neg_reg ? (11'sd128 - $signed({2'b00, quo_reg}))
                         : (11'sd128 + $signed({2'b00, quo_reg}));
        if (c_sgn < 11'sd0)
        begin
            c1 = 8'd0;
        end
        else if (c_sgn > 11'sd255)
        begin
            c1 = 8'd255;
        end
        else
        begin
            c1 = c_sgn[7:0];
        end
        c2_sum = {1'b0, c1} + {3'b000, bri_reg};
        c2     = c2_sum[8] ? 8'd255 : c2_sum[7:0];
        // c*255 as (c << 8) - c; the first Newton step is exactly (c + 255) / 2
        g_prod = {c2, 8'd0} - {8'd0, c2};
        x1_sum = {1'b0, c2} + 9'd255;
        r2     = {rem_reg, low_reg[8]};
        ge     = r2 >= {1'b0, x1_reg};
        r2_sub = r2 - {1'b0, x1_reg};
        x2_sum = {2'b00, x1_reg} + {1'b0, gq_reg};
        x2     = x2_sum[9:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_en_reg <= 1'b1;
            pct_reg    <= RST_CONTRAST;
            bri_reg    <= RST_BRIGHTNESS;
            gam_en_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ADJUST_ENABLE:     adj_en_reg <= cfg.data[0];
                REG_CONTRAST_PERCENT:  pct_reg    <= cfg.data;
                REG_BRIGHTNESS_OFFSET: bri_reg    <= cfg.data[5:0];
                REG_GAMMA_ENABLE:      gam_en_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= adj_en_reg ? F_MUL : F_PUSH;
                    end
                end
                F_MUL: state_reg <= F_SCL;
                F_SCL: state_reg <= F_ADJ;
                F_ADJ: state_reg <= (gam_en_reg && c2 != 8'd0) ? F_DIV : F_PUSH;
                F_DIV:
                begin
                    if (cnt_reg == 4'd0)
                    begin
                        state_reg <= F_GAM;
                    end
                end
                F_GAM: state_reg <= F_PUSH;
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    word_reg.tone           <= pix_word.gray;
                    word_reg.column         <= pix_word.column;
                    word_reg.first_of_image <= pix_word.first_of_image;
                    word_reg.last_in_row    <= pix_word.last_in_row;
                end
            end
            F_MUL:
            begin
                neg_reg  <= word_reg.tone < MID_GRAY;
                prod_reg <= 16'(mag) * 16'(pct_reg);
            end
            F_SCL:
            begin
                quo_reg <= scl[RECIP_SHIFT+8:RECIP_SHIFT];
            end
            F_ADJ:
            begin
                word_reg.tone <= c2;
                x1_reg  <= x1_sum[8:1];
                rem_reg <= {1'b0, g_prod[15:9]};
                low_reg <= g_prod[8:0];
                gq_reg  <= 9'd0;
                cnt_reg <= 4'd8;
            end
            F_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                rem_reg <= ge ? r2_sub[7:0] : r2[7:0];
                low_reg <= {low_reg[7:0], 1'b0};
                gq_reg  <= {gq_reg[7:0], ge};
                cnt_reg <= cnt_reg - 4'd1;
            end
            F_GAM:
            begin
                word_reg.tone <= x2[8] ? 8'd255 : x2[7:0];
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/atkd2_fifo.sv =====
// Short word queue between the tone front end and the dither engine.
`default_nettype none
module atkd2_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire atkd2_pkg::tone_word_t  push_word,
    output logic                        full,
    input  wire logic                   pop,
    output atkd2_pkg::tone_word_t       pop_word,
    output logic                        empty
);
    import atkd2_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    tone_word_t   slot_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full     = count_reg == (PW+1)'(Q_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_word = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/atkd2_back.sv =====
// Dither engine: error row stores, quantizer, error spreading, row rotation.
`default_nettype none
module atkd2_back #(
    parameter int MAX_WIDTH = 512
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_empty,
    output logic                        q_pop,
    input  wire atkd2_pkg::tone_word_t  q_word,
    output logic                        boot_clear,
    output logic                        dot_valid,
    input  wire logic                   dot_stall,
    output atkd2_pkg::dot_word_t        dot_word
);
    import atkd2_pkg::*;

    localparam int DEPTH = MAX_WIDTH + 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (AW > 10) ? AW : 10;

    typedef enum logic [6:0] {
        B_CLR_ALL = 7'b0000001,
        B_POP     = 7'b0000010,
        B_RD      = 7'b0000100,
        B_QNT     = 7'b0001000,
        B_URD     = 7'b0010000,
        B_UWR     = 7'b0100000,
        B_CLR_ROW = 7'b1000000
    } bstate_t;

    bstate_t    state_reg;
    logic       resume_reg;
    logic [1:0] rot_reg;
    logic [1:0] step_reg;
    logic [AW-1:0] sweep_reg;
    tone_word_t cur_reg;
    logic [3:0] err_reg;
    logic       dot_valid_reg;
    dot_word_t  dot_reg;

    logic          mem_we    [3];
    logic [AW-1:0] mem_waddr [3];
    logic [7:0]    mem_wdata [3];
    logic [AW-1:0] mem_raddr [3];
    logic [7:0]    mem_rdata [3];

    logic       in_range;
    logic       sweep_end;
    logic       out_free;
    logic [1:0] rot_nx;
    logic [SW-1:0] col_ext;
    logic [7:0] rd0;
    logic [9:0] sum10;
    logic [7:0] a_val;
    logic [1:0] lvl;
    logic [7:0] qv;
    logic [8:0] diff9;

    assign in_range   = int'(cur_reg.column) < MAX_WIDTH;
    assign sweep_end  = sweep_reg == AW'(DEPTH - 1);
    assign out_free   = !dot_valid_reg || !dot_stall;
    assign rot_nx     = (rot_reg == 2'd2) ? 2'd0 : rot_reg + 2'd1;
    assign col_ext    = SW'(cur_reg.column);
    assign q_pop      = (state_reg == B_POP) && !q_empty;
    assign boot_clear = (state_reg == B_CLR_ALL) && !resume_reg;
    assign dot_valid  = dot_valid_reg;
    assign dot_word   = dot_reg;

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_row
            atkd2_row_mem #(
                .DEPTH (DEPTH),
                .AW    (AW)
            ) u_mem (
                .clk   (clk),
                .we    (mem_we[gi]),
                .waddr (mem_waddr[gi]),
                .wdata (mem_wdata[gi]),
                .raddr (mem_raddr[gi]),
                .rdata (mem_rdata[gi])
            );
        end
    endgenerate

    // per physical store: role 0 current row, 1 next row, 2 row after next
    always_comb
    begin
        logic [1:0]    role;
        logic          active;
        logic [SW-1:0] uaddr;
        logic [8:0]    s9;
        for (int j = 0; j < 3; j++)
        begin
            if (2'(j) == rot_reg)
            begin
                role = 2'd0;
            end
            else if (2'(j) == rot_nx)
            begin
                role = 2'd1;
            end
            else
            begin
                role = 2'd2;
            end
            case (role)
                2'd0:
                begin
                    active = step_reg != 2'd2;
                    uaddr  = col_ext + SW'(3) + SW'(step_reg);
                end
                2'd1:
                begin
                    active = 1'b1;
                    uaddr  = col_ext + SW'(1) + SW'(step_reg);
                end
                default:
                begin
                    active = step_reg == 2'd0;
                    uaddr  = col_ext + SW'(2);
                end
            endcase
            s9 = {mem_rdata[j][7], mem_rdata[j]} + {{5{err_reg[3]}}, err_reg};
            mem_we[j]    = 1'b0;
            mem_waddr[j] = sweep_reg;
            mem_wdata[j] = 8'd0;
            mem_raddr[j] = AW'(col_ext + SW'(2));
            case (state_reg)
                B_CLR_ALL: mem_we[j] = 1'b1;
                B_CLR_ROW: mem_we[j] = role == 2'd0;
                B_URD:     mem_raddr[j] = uaddr[AW-1:0];
                B_UWR:
                begin
                    mem_we[j]    = active;
                    mem_waddr[j] = uaddr[AW-1:0];
                    if (s9[8] != s9[7])
                    begin
                        mem_wdata[j] = s9[8] ? 8'h80 : 8'h7F;
                    end
                    else
                    begin
                        mem_wdata[j] = s9[7:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rd0   = in_range ? mem_rdata[rot_reg] : 8'd0;
        sum10 = {2'b00, cur_reg.tone} + {{2{rd0[7]}}, rd0};
        if (sum10[9])
        begin
            a_val = 8'd0;
        end
        else if (sum10[8])
        begin
            a_val = 8'd255;
        end
        else
        begin
            a_val = sum10[7:0];
        end
        if (a_val < THR_DARK)
        begin
            lvl = LVL_BLACK;
            qv  = 8'd0;
        end
        else if (a_val < THR_LIGHT)
        begin
            lvl = LVL_DARK;
            qv  = VAL_DARK;
        end
        else if (a_val < THR_WHITE)
        begin
            lvl = LVL_LIGHT;
            qv  = VAL_LIGHT;
        end
        else
        begin
            lvl = LVL_WHITE;
            qv  = VAL_WHITE;
        end
        diff9 = {1'b0, a_val} - {1'b0, qv};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLR_ALL;
            resume_reg    <= 1'b0;
            rot_reg       <= 2'd0;
            step_reg      <= 2'd0;
            sweep_reg     <= '0;
            dot_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == B_QNT && out_free)
            begin
                dot_valid_reg <= 1'b1;
            end
            else if (!dot_stall)
            begin
                dot_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLR_ALL:
                begin
                    if (sweep_end)
                    begin
                        sweep_reg <= '0;
                        state_reg <= resume_reg ? B_RD : B_POP;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + AW'(1);
                    end
                end
                B_POP:
                begin
                    if (!q_empty)
                    begin
                        resume_reg <= 1'b1;
                        state_reg  <= q_word.first_of_image ? B_CLR_ALL : B_RD;
                    end
                end
                B_RD: state_reg <= B_QNT;
                B_QNT:
                begin
                    if (out_free)
                    begin
                        step_reg <= 2'd0;
                        if (in_range)
                        begin
                            state_reg <= B_URD;
                        end
                        else
                        begin
                            state_reg <= cur_reg.last_in_row ? B_CLR_ROW : B_POP;
                        end
                    end
                end
                B_URD: state_reg <= B_UWR;
                B_UWR:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd2)
                    begin
                        state_reg <= cur_reg.last_in_row ? B_CLR_ROW : B_POP;
                    end
                    else
                    begin
                        state_reg <= B_URD;
                    end
                end
                B_CLR_ROW:
                begin
                    if (sweep_end)
                    begin
                        sweep_reg <= '0;
                        rot_reg   <= rot_nx;
                        state_reg <= B_POP;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + AW'(1);
                    end
                end
                default: state_reg <= B_CLR_ALL;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_word;
        end
        if (state_reg == B_QNT && out_free)
        begin
            dot_reg.level      <= lvl;
            dot_reg.out_column <= cur_reg.column;
            err_reg            <= diff9[6:3];
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the 2-bit Atkinson ditherer.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import atkd2_pkg::*;

    localparam int MW   = 512;
    localparam int ROWD = MW + 4;
    localparam int SETTLE = 2 * ROWD + 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic pix_valid = 1'b0;
    logic pix_stall;
    pix_word_t pix_word = '0;
    logic dot_valid;
    logic dot_stall = 1'b0;
    dot_word_t dot_word;

    atkinson_dither_2bit #(.MAX_WIDTH(MW)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_word(pix_word),
        .dot_valid(dot_valid), .dot_stall(dot_stall), .dot_word(dot_word)
    );

    always #5 clk = ~clk;

    // predictor state
    logic signed [7:0] err_row [3][ROWD];
    int unsigned rot;
    bit adj_en = 1'b1;
    logic [7:0] contrast = RST_CONTRAST;
    logic [5:0] bright = RST_BRIGHTNESS;
    bit gam_en = 1'b1;

    pix_word_t pixel_q[$];
    dot_word_t dot_q[$];
    int errors = 0;
    int taken_cnt = 0;
    int send_idle = 0;
    int recv_idle = 0;
    bit pix_took = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;

    function automatic int clamp8(int v);
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    function automatic int tone_of(int g);
        int c, prod, x;
        if (!adj_en)
            return g;
        c = clamp8(((g - 128) * int'(contrast)) / 100 + 128);
        c = clamp8(c + int'(bright));
        if (gam_en && c > 0)
        begin
            prod = c * 255;
            x = c;
            x = (x + prod / x) / 2;
            x = (x + prod / x) / 2;
            c = (x > 255) ? 255 : x;
        end
        return c;
    endfunction

    function automatic void spread(int r, int idx, int e);
        int v;
        v = int'(err_row[r][idx]) + e;
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        err_row[r][idx] = v[7:0];
    endfunction

    function automatic void clear_row(int r);
        for (int i = 0; i < ROWD; i++)
            err_row[r][i] = '0;
    endfunction

    function automatic dot_word_t dither_pixel(pix_word_t w);
        dot_word_t d;
        int r0, r1, r2, col, a, qv, e;
        logic [1:0] lvl;
        r0 = rot % 3;
        r1 = (r0 + 1) % 3;
        r2 = (r0 + 2) % 3;
        col = int'(w.column);
        if (w.first_of_image)
            for (int r = 0; r < 3; r++)
                clear_row(r);
        a = tone_of(int'(w.gray));
        if (col < MW)
            a += int'(err_row[r0][col + 2]);
        a = clamp8(a);
        if (a < int'(THR_DARK)) begin lvl = LVL_BLACK; qv = 0; end
        else if (a < int'(THR_LIGHT)) begin lvl = LVL_DARK; qv = int'(VAL_DARK); end
        else if (a < int'(THR_WHITE)) begin lvl = LVL_LIGHT; qv = int'(VAL_LIGHT); end
        else begin lvl = LVL_WHITE; qv = int'(VAL_WHITE); end
        e = (a - qv) >>> 3;
        if (col < MW)
        begin
            spread(r0, col + 3, e);
            spread(r0, col + 4, e);
            spread(r1, col + 1, e);
            spread(r1, col + 2, e);
            spread(r1, col + 3, e);
            spread(r2, col + 2, e);
        end
        if (w.last_in_row)
        begin
            clear_row(r0);
            rot = r1;
        end
        d.level = lvl;
        d.out_column = w.column;
        return d;
    endfunction

    // accept, predict and check at the rising edge
    always @(posedge clk)
    begin
        dot_word_t exp_dot;
        pix_took <= pix_valid && !pix_stall;
        if (rst_n && pix_valid && !pix_stall)
        begin
            dot_q.push_back(dither_pixel(pix_word));
            taken_cnt++;
        end
        if (rst_n && dot_valid && !dot_stall)
        begin
            if (dot_q.size() == 0)
            begin
                $display("%0t: unexpected word, got level %0d col %0d",
                         $realtime, dot_word.level, dot_word.out_column);
                errors++;
            end
            else
            begin
                exp_dot = dot_q.pop_front();
                if (dot_word.level !== exp_dot.level)
                begin
                    $display("%0t: level mismatch col %0d, expected %0d got %0d",
                             $realtime, exp_dot.out_column, exp_dot.level, dot_word.level);
                    errors++;
                end
                if (dot_word.out_column !== exp_dot.out_column)
                begin
                    $display("%0t: column mismatch, expected %0d got %0d",
                             $realtime, exp_dot.out_column, dot_word.out_column);
                    errors++;
                end
            end
        end
    end

    // pixel sender
    always @(negedge clk)
    begin
        if (!pix_valid || pix_took)
        begin
            if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                pix_valid <= 1'b1;
                pix_word <= pixel_q.pop_front();
            end
            else
                pix_valid <= 1'b0;
        end
    end

    // dot receiver, with one long hold-off to back up the pipe
    always @(negedge clk)
    begin
        if (!hold_done && taken_cnt >= 300)
        begin
            hold_done = 1'b1;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            dot_stall <= 1'b1;
        end
        else
            dot_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    task automatic reg_write(logic [7:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_ADJUST_ENABLE:     adj_en = val[0];
            REG_CONTRAST_PERCENT:  contrast = val;
            REG_BRIGHTNESS_OFFSET: bright = val[5:0];
            REG_GAMMA_ENABLE:      gam_en = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pixel_q.size() == 0 && !pix_valid && dot_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_gray();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one image of well-formed rows
    task automatic push_image(int rows, int width);
        pix_word_t w;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < width; c++)
            begin
                w.gray = rand_gray();
                w.column = 9'(c);
                w.first_of_image = (r == 0 && c == 0);
                w.last_in_row = (c == width - 1);
                pixel_q.push_back(w);
            end
    endtask

    task automatic push_noise(int n);
        pix_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.gray = 8'($urandom_range(0, 255));
            w.column = 9'($urandom_range(0, 511));
            w.first_of_image = ($urandom_range(0, 15) == 0);
            w.last_in_row = ($urandom_range(0, 7) == 0);
            pixel_q.push_back(w);
        end
    endtask

    task automatic random_phase(int n_items, bit wide_row);
        int made;
        made = 0;
        if (wide_row)
        begin
            push_image(1, MW);
            made = MW;
        end
        while (made < n_items)
        begin
            int rows, width;
            if ($urandom_range(0, 5) == 0)
            begin
                push_noise(12);
                made += 12;
            end
            else
            begin
                rows = $urandom_range(1, 4);
                width = $urandom_range(2, 24);
                push_image(rows, width);
                made += rows * width;
            end
        end
        drain();
    endtask

    initial
    begin
        pix_word_t w;
        logic [7:0] dir_gray [10];
        dir_gray = '{8'd0, 8'd255, 8'd42, 8'd43, 8'd127,
                     8'd128, 8'd212, 8'd213, 8'd1, 8'd254};
        for (int r = 0; r < 3; r++)
            clear_row(r);
        rot = 0;
        send_idle = 19;
        recv_idle = 52;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: threshold grays, row end and image start together
        for (int i = 0; i < 10; i++)
        begin
            w.gray = dir_gray[i];
            w.column = 9'(i);
            w.first_of_image = (i == 0);
            w.last_in_row = (i == 9);
            pixel_q.push_back(w);
        end
        w = '{gray: 8'd200, column: 9'd0, first_of_image: 1'b1, last_in_row: 1'b1};
        pixel_q.push_back(w);
        w = '{gray: 8'd90, column: 9'd511, first_of_image: 1'b0, last_in_row: 1'b0};
        pixel_q.push_back(w);
        w = '{gray: 8'd160, column: 9'd510, first_of_image: 1'b0, last_in_row: 1'b1};
        pixel_q.push_back(w);
        drain();

        reg_write(REG_ADJUST_ENABLE, 8'd0);
        for (int i = 0; i < 8; i++)
        begin
            w.gray = (i[0]) ? 8'd255 : 8'd0;
            w.column = 9'(i);
            w.first_of_image = (i == 0);
            w.last_in_row = (i == 7);
            pixel_q.push_back(w);
        end
        drain();
        random_phase(200, 1'b0);

        reg_write(REG_ADJUST_ENABLE, 8'd1);
        reg_write(REG_CONTRAST_PERCENT, 8'd0);
        reg_write(REG_BRIGHTNESS_OFFSET, 8'd0);
        reg_write(REG_GAMMA_ENABLE, 8'd0);
        reg_write(8'd7, 8'd1);      // unmapped index, no effect
        random_phase(200, 1'b0);

        send_idle = 52;
        recv_idle = 19;
        reg_write(REG_CONTRAST_PERCENT, 8'd255);
        reg_write(REG_BRIGHTNESS_OFFSET, 8'hFF);   // masked to 63
        reg_write(REG_GAMMA_ENABLE, 8'd1);
        random_phase(200, 1'b0);

        reg_write(REG_CONTRAST_PERCENT, 8'($urandom_range(60, 160)));
        reg_write(REG_BRIGHTNESS_OFFSET, 8'($urandom_range(0, 63)));
        reg_write(REG_GAMMA_ENABLE, 8'd0);
        random_phase(150, 1'b0);

        send_idle = 0;
        recv_idle = 0;
        reg_write(REG_ADJUST_ENABLE, 8'd0);
        random_phase(520, 1'b1);

        reg_write(REG_ADJUST_ENABLE, 8'd1);
        reg_write(REG_CONTRAST_PERCENT, 8'($urandom_range(0, 255)));
        reg_write(REG_BRIGHTNESS_OFFSET, 8'($urandom_range(0, 63)));
        reg_write(REG_GAMMA_ENABLE, 8'd1);
        random_phase(150, 1'b0);

        if (errors == 0)
            $display("PASS atkinson_dither_2bit");
        else
            $display("FAIL atkinson_dither_2bit");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL atkinson_dither_2bit");
        $finish;
    end
endmodule
`default_nettype wire
